// ----- sv/csl_pkg.sv -----
// shared types, token codes and constants for the c subset lexer
package csl_pkg;

    // longest lexeme count kept, limited by the 5-bit length field
    localparam int MAX_LEXEME = 31;
    localparam int LEN_CAP    = (MAX_LEXEME < 31) ? MAX_LEXEME : 31;

    // token queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // token kind codes
    localparam logic [4:0] K_SEMI        = 5'd0;
    localparam logic [4:0] K_COMMA       = 5'd1;
    localparam logic [4:0] K_IDENT       = 5'd2;
    localparam logic [4:0] K_INCR        = 5'd3;
    localparam logic [4:0] K_PLUS_ASSIGN = 5'd4;
    localparam logic [4:0] K_ADD         = 5'd5;
    localparam logic [4:0] K_EQ_CMP      = 5'd6;
    localparam logic [4:0] K_ASSIGN      = 5'd7;
    localparam logic [4:0] K_LPAREN      = 5'd8;
    localparam logic [4:0] K_RPAREN      = 5'd9;
    localparam logic [4:0] K_LBRACE      = 5'd10;
    localparam logic [4:0] K_RBRACE      = 5'd11;
    localparam logic [4:0] K_IF          = 5'd12;
    localparam logic [4:0] K_ELSE        = 5'd13;
    localparam logic [4:0] K_WHILE       = 5'd14;
    localparam logic [4:0] K_FOR         = 5'd15;
    localparam logic [4:0] K_RETURN      = 5'd16;
    localparam logic [4:0] K_NUMBER      = 5'd17;
    localparam logic [4:0] K_END         = 5'd18;

    // input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in;

    // result item
    typedef struct packed {
        logic [4:0] token_kind;
        logic [4:0] token_length;
        logic       last_of_run;
    } t_out;

    // one token without run marking
    typedef struct packed {
        logic [4:0] kind;
        logic [4:0] length;
    } t_tok;

    // tokens caused by one input byte: one or two
    typedef struct packed {
        logic two;
        t_tok t0;
        t_tok t1;
    } t_pair;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic nonempty;
    } t_qstat;

endpackage

// ----- sv/csl_front.sv -----
// front part: scan state machine that classifies bytes into token pairs
module csl_front import csl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_take,
    input  t_in   i_data,
    output logic  o_push,
    output t_pair o_pair
);

    typedef enum logic [5:0] {
        MODE_IDLE = 6'b000001,
        MODE_PLUS = 6'b000010,
        MODE_EQ   = 6'b000100,
        MODE_PCT  = 6'b001000,
        MODE_WORD = 6'b010000,
        MODE_NUM  = 6'b100000
    } t_mode;

    // keyword text, first byte in the low bits
    localparam logic [47:0] KW_IF     = 48'h0000_0000_6669;
    localparam logic [47:0] KW_ELSE   = 48'h0000_6573_6c65;
    localparam logic [47:0] KW_WHILE  = 48'h0065_6c69_6877;
    localparam logic [47:0] KW_FOR    = 48'h0000_0072_6f66;
    localparam logic [47:0] KW_RETURN = 48'h6e72_7574_6572;

    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_PCT    = 8'h25;

    localparam int PREFIX_BYTES = 6;

    t_mode       r_mode, n_mode;
    logic [4:0]  r_len, n_len;
    logic [47:0] r_prefix, n_prefix;

    function automatic logic [4:0] word_kind(input logic [47:0] p);
        logic [4:0] k;
        k = K_IDENT;
        if (p == KW_IF) k = K_IF;
        if (p == KW_ELSE) k = K_ELSE;
        if (p == KW_WHILE) k = K_WHILE;
        if (p == KW_FOR) k = K_FOR;
        if (p == KW_RETURN) k = K_RETURN;
        return k;
    endfunction

    logic [7:0] b;
    logic       is_letter, is_digit;
    assign b         = i_data.in_byte;
    assign is_letter = (b inside {[8'h61:8'h7a]}) || (b inside {[8'h41:8'h5a]});
    assign is_digit  = b inside {[8'h30:8'h39]};

    // scan of the byte from idle
    logic       idle_tok;
    logic [4:0] idle_kind;
    t_mode      idle_mode;
    always_comb begin
        idle_tok  = 1'b1;
        idle_kind = K_SEMI;
        idle_mode = MODE_IDLE;
        case (b)
            CH_SEMI:   idle_kind = K_SEMI;
            CH_COMMA:  idle_kind = K_COMMA;
            CH_LPAREN: idle_kind = K_LPAREN;
            CH_RPAREN: idle_kind = K_RPAREN;
            CH_LBRACE: idle_kind = K_LBRACE;
            CH_RBRACE: idle_kind = K_RBRACE;
            CH_PLUS: begin
                idle_tok  = 1'b0;
                idle_mode = MODE_PLUS;
            end
            CH_EQ: begin
                idle_tok  = 1'b0;
                idle_mode = MODE_EQ;
            end
            CH_PCT: begin
                idle_tok  = 1'b0;
                idle_mode = MODE_PCT;
            end
            default: begin
                idle_tok = 1'b0;
                if (is_letter) idle_mode = MODE_WORD;
                else if (is_digit) idle_mode = MODE_NUM;
            end
        endcase
    end

    // byte appended to a running word or number
    logic [47:0] app_prefix;
    logic [4:0]  app_len;
    always_comb begin
        app_prefix = r_prefix;
        if (r_len < 5'(PREFIX_BYTES)) begin
            for (int i = 0; i < PREFIX_BYTES; i++) begin
                if (r_len == 5'(i)) app_prefix[8*i +: 8] = b;
            end
        end else begin
            app_prefix = '0;
        end
        app_len = (r_len < 5'(LEN_CAP)) ? r_len + 5'd1 : r_len;
    end

    // first token from the pending lexeme, second from the rescan
    logic va, vb, rescan;
    t_tok ta, tb;
    always_comb begin
        va       = 1'b0;
        vb       = 1'b0;
        rescan   = 1'b0;
        ta       = '{kind: K_ADD, length: 5'd1};
        tb       = '{kind: K_END, length: 5'd0};
        n_mode   = r_mode;
        n_len    = r_len;
        n_prefix = r_prefix;
        if (i_data.end_of_input) begin
            vb = 1'b1;
            case (r_mode)
                MODE_PLUS: begin
                    va = 1'b1;
                    ta = '{kind: K_ADD, length: 5'd1};
                end
                MODE_EQ: begin
                    va = 1'b1;
                    ta = '{kind: K_ASSIGN, length: 5'd1};
                end
                MODE_PCT: begin
                    va = 1'b1;
                    ta = '{kind: K_IDENT, length: 5'd1};
                end
                MODE_WORD: begin
                    va = 1'b1;
                    ta = '{kind: word_kind(r_prefix), length: r_len};
                end
                MODE_NUM: begin
                    va = 1'b1;
                    ta = '{kind: K_NUMBER, length: r_len};
                end
                default: va = 1'b0;
            endcase
            n_mode   = MODE_IDLE;
            n_len    = '0;
            n_prefix = '0;
        end else begin
            case (r_mode)
                MODE_PLUS: begin
                    va = 1'b1;
                    if (b == CH_PLUS) begin
                        ta     = '{kind: K_INCR, length: 5'd2};
                        n_mode = MODE_IDLE;
                    end else if (b == CH_EQ) begin
                        ta     = '{kind: K_PLUS_ASSIGN, length: 5'd2};
                        n_mode = MODE_IDLE;
                    end else begin
                        ta     = '{kind: K_ADD, length: 5'd1};
                        rescan = 1'b1;
                    end
                end
                MODE_EQ: begin
                    va = 1'b1;
                    if (b == CH_EQ) begin
                        ta     = '{kind: K_EQ_CMP, length: 5'd2};
                        n_mode = MODE_IDLE;
                    end else begin
                        ta     = '{kind: K_ASSIGN, length: 5'd1};
                        rescan = 1'b1;
                    end
                end
                MODE_PCT: begin
                    va     = 1'b1;
                    ta     = '{kind: K_IDENT, length: 5'd2};
                    n_mode = MODE_IDLE;
                end
                MODE_WORD: begin
                    if (is_letter || is_digit) begin
                        n_len    = app_len;
                        n_prefix = app_prefix;
                    end else begin
                        va     = 1'b1;
                        ta     = '{kind: word_kind(r_prefix), length: r_len};
                        rescan = 1'b1;
                    end
                end
                MODE_NUM: begin
                    if (is_digit) begin
                        n_len    = app_len;
                        n_prefix = app_prefix;
                    end else begin
                        va     = 1'b1;
                        ta     = '{kind: K_NUMBER, length: r_len};
                        rescan = 1'b1;
                    end
                end
                default: rescan = 1'b1;
            endcase
            if (rescan) begin
                vb     = idle_tok;
                tb     = '{kind: idle_kind, length: 5'd1};
                n_mode = idle_mode;
                if (idle_mode == MODE_WORD || idle_mode == MODE_NUM) begin
                    n_len    = 5'd1;
                    n_prefix = {40'd0, b};
                end
            end
        end
    end

    // pack into a pair for the queue
    always_comb begin
        o_push      = i_take && (va || vb);
        o_pair.two  = va && vb;
        o_pair.t0   = va ? ta : tb;
        o_pair.t1   = tb;
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_len    <= '0;
            r_prefix <= '0;
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_len    <= n_len;
            r_prefix <= n_prefix;
        end
    end

endmodule

// ----- sv/csl_queue.sv -----
// short token pair queue between front and back
module csl_queue import csl_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_pair  i_pair,
    input  logic   i_pop,
    output t_qstat o_stat,
    output t_pair  o_head
);

    t_pair             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_stat.full     = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.nonempty = (r_cnt != '0);
    assign o_head          = r_mem[r_rd];

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_pair;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPTR_W'(1);
            if (i_pop) r_rd <= r_rd + QPTR_W'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- sv/csl_back.sv -----
// back part: output register that sends the tokens of each pair in order
module csl_back import csl_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qstat i_stat,
    input  t_pair  i_head,
    output logic   o_pop,
    output logic   o_out_valid,
    input  logic   i_out_stall,
    output t_out   o_out_data
);

    logic  r_busy;
    logic  r_idx;
    t_pair r_ent;
    logic  xfer, done;

    assign xfer  = r_busy && !i_out_stall;
    assign done  = xfer && (r_idx || !r_ent.two);
    assign o_pop = i_stat.nonempty && (!r_busy || done);

    assign o_out_valid             = r_busy;
    assign o_out_data.token_kind   = r_idx ? r_ent.t1.kind : r_ent.t0.kind;
    assign o_out_data.token_length = r_idx ? r_ent.t1.length : r_ent.t0.length;
    assign o_out_data.last_of_run  = r_idx || !r_ent.two;

    // pair register, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_pop) r_ent <= i_head;
    end

    // output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 1'b0;
        end else if (done) begin
            r_busy <= 1'b0;
            r_idx  <= 1'b0;
        end else if (xfer) begin
            r_idx  <= 1'b1;
        end
    end

endmodule

// ----- sv/c_subset_lexer_unit.sv -----
// top level of the c subset lexer: front scanner, token queue, output back end
//
// channel   direction  handshake               payload
// input     in         i_in_valid / o_in_stall  i_in_data  (t_in)
// output    out        o_out_valid / i_out_stall o_out_data (t_out)
//
// one byte is taken every cycle while the four-entry token queue has room
// a byte gives zero, one or two tokens; the back end sends one token per
// cycle while the output is not stalled, so a steady run of two-token bytes fills the queue
// a byte's tokens pass the queue and then the back end pair register before they are offered
// reset is synchronous and clears scan state, queue and output valid
// an output stall holds the token; the front stalls only when the queue is full
module c_subset_lexer_unit import csl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_qstat q_stat;
    t_pair  f_pair, q_head;
    logic   f_push, q_pop, take;

    assign o_in_stall = q_stat.full;
    assign take       = i_in_valid && !o_in_stall;

    // byte scanner
    csl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_data  (i_in_data),
        .o_push  (f_push),
        .o_pair  (f_pair)
    );

    // token queue
    csl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_pair  (f_pair),
        .i_pop   (q_pop),
        .o_stat  (q_stat),
        .o_head  (q_head)
    );

    // token sender
    csl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stat      (q_stat),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- sv/csl_checker.sv -----
// port-level checker for the c subset lexer and its bind
module csl_checker import csl_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // a stalled token holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled token changed");

    // a stalled input byte holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_data)))
        else $error("stalled input changed");

    // end token has zero length and closes its run; others carry a byte and a known kind
    a_tok_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid
        |-> ((o_out_data.token_kind == K_END)
             ? (o_out_data.token_length == 5'd0 && o_out_data.last_of_run)
             : (o_out_data.token_length != 5'd0 && o_out_data.token_kind < K_END)))
        else $error("bad token");

    // first token of a pair is followed by its partner without a gap
    a_pair_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_data.last_of_run) |=> o_out_valid)
        else $error("second token of a run missing");

endmodule

bind c_subset_lexer_unit csl_checker u_csl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ----- bench/c_subset_lexer_unit_tb.sv -----
// self-checking testbench for the c subset lexer: token prediction, random streams, stalls
module c_subset_lexer_unit_tb;
    import csl_pkg::*;

    // scanner state kept by the token predictor
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_PLUS,
        SCAN_EQ,
        SCAN_PCT,
        SCAN_WORD,
        SCAN_NUM
    } t_scan;

    // predicts the tokens of each accepted byte and checks the tokens that come out
    class t_token_scoreboard;
        localparam logic [47:0] TXT_IF     = "if";
        localparam logic [47:0] TXT_ELSE   = "else";
        localparam logic [47:0] TXT_WHILE  = "while";
        localparam logic [47:0] TXT_FOR    = "for";
        localparam logic [47:0] TXT_RETURN = "return";

        t_scan       mode;
        logic [4:0]  word_len;
        logic [47:0] word_text;
        t_out        expected_tokens[$];
        int          errors;

        function new();
            clear_scan();
            errors = 0;
        endfunction

        function void clear_scan();
            mode      = SCAN_IDLE;
            word_len  = '0;
            word_text = '0;
        endfunction

        function bit is_letter(logic [7:0] b);
            return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
        endfunction

        function bit is_digit(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function void push_token(logic [4:0] kind, logic [4:0] len);
            t_out tok;
            tok.token_kind   = kind;
            tok.token_length = len;
            tok.last_of_run  = 1'b0;
            expected_tokens.push_back(tok);
        endfunction

        // keep the first six word bytes; longer words can never be keywords
        function void take_char(logic [7:0] b);
            if (word_len < 6) begin
                word_text = {word_text[39:0], b};
            end else begin
                word_text = '0;
            end
            if (word_len < LEN_CAP) begin
                word_len++;
            end
        endfunction

        function logic [4:0] word_kind();
            case (word_text)
                TXT_IF:     return K_IF;
                TXT_ELSE:   return K_ELSE;
                TXT_WHILE:  return K_WHILE;
                TXT_FOR:    return K_FOR;
                TXT_RETURN: return K_RETURN;
                default:    return K_IDENT;
            endcase
        endfunction

        // byte seen with nothing pending
        function void scan_fresh(logic [7:0] b);
            mode = SCAN_IDLE;
            case (b)
                ";": push_token(K_SEMI, 5'd1);
                ",": push_token(K_COMMA, 5'd1);
                "(": push_token(K_LPAREN, 5'd1);
                ")": push_token(K_RPAREN, 5'd1);
                "{": push_token(K_LBRACE, 5'd1);
                "}": push_token(K_RBRACE, 5'd1);
                "+": mode = SCAN_PLUS;
                "=": mode = SCAN_EQ;
                "%": mode = SCAN_PCT;
                default: begin
                    if (is_letter(b) || is_digit(b)) begin
                        mode      = is_letter(b) ? SCAN_WORD : SCAN_NUM;
                        word_len  = '0;
                        word_text = '0;
                        take_char(b);
                    end
                end
            endcase
        endfunction

        // accepted input transfer: queue the tokens it causes
        function void note_byte(t_in d);
            int   first;
            t_out tail;
            first = expected_tokens.size();
            if (d.end_of_input) begin
                case (mode)
                    SCAN_PLUS: push_token(K_ADD, 5'd1);
                    SCAN_EQ:   push_token(K_ASSIGN, 5'd1);
                    SCAN_PCT:  push_token(K_IDENT, 5'd1);
                    SCAN_WORD: push_token(word_kind(), word_len);
                    SCAN_NUM:  push_token(K_NUMBER, word_len);
                    default: ;
                endcase
                push_token(K_END, 5'd0);
                clear_scan();
            end else begin
                case (mode)
                    SCAN_PLUS: begin
                        if (d.in_byte == "+") begin
                            push_token(K_INCR, 5'd2);
                            mode = SCAN_IDLE;
                        end else if (d.in_byte == "=") begin
                            push_token(K_PLUS_ASSIGN, 5'd2);
                            mode = SCAN_IDLE;
                        end else begin
                            push_token(K_ADD, 5'd1);
                            scan_fresh(d.in_byte);
                        end
                    end
                    SCAN_EQ: begin
                        if (d.in_byte == "=") begin
                            push_token(K_EQ_CMP, 5'd2);
                            mode = SCAN_IDLE;
                        end else begin
                            push_token(K_ASSIGN, 5'd1);
                            scan_fresh(d.in_byte);
                        end
                    end
                    SCAN_PCT: begin
                        push_token(K_IDENT, 5'd2);
                        mode = SCAN_IDLE;
                    end
                    SCAN_WORD: begin
                        if (is_letter(d.in_byte) || is_digit(d.in_byte)) begin
                            take_char(d.in_byte);
                        end else begin
                            push_token(word_kind(), word_len);
                            scan_fresh(d.in_byte);
                        end
                    end
                    SCAN_NUM: begin
                        if (is_digit(d.in_byte)) begin
                            take_char(d.in_byte);
                        end else begin
                            push_token(K_NUMBER, word_len);
                            scan_fresh(d.in_byte);
                        end
                    end
                    default: scan_fresh(d.in_byte);
                endcase
            end
            // mark the final token of this byte
            if (expected_tokens.size() > first) begin
                tail = expected_tokens.pop_back();
                tail.last_of_run = 1'b1;
                expected_tokens.push_back(tail);
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // accepted output transfer: compare with the oldest expected token
        task check_token(t_out got);
            t_out want;
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected token kind %0d length %0d",
                                          got.token_kind, got.token_length));
                return;
            end
            want = expected_tokens.pop_front();
            if (got.token_kind !== want.token_kind) begin
                report_mismatch($sformatf("token_kind %0d, expected %0d",
                                          got.token_kind, want.token_kind));
            end
            if (got.token_length !== want.token_length) begin
                report_mismatch($sformatf("token_length %0d, expected %0d (kind %0d)",
                                          got.token_length, want.token_length,
                                          want.token_kind));
            end
            if (got.last_of_run !== want.last_of_run) begin
                report_mismatch($sformatf("last_of_run %0b, expected %0b (kind %0d)",
                                          got.last_of_run, want.last_of_run,
                                          want.token_kind));
            end
        endtask
    endclass

    localparam int QUIET_LIMIT = 1000;
    localparam int TAIL_CYCLES = 20;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    t_token_scoreboard sb = new();
    int    items_sent   = 0;
    int    quiet_cycles = 0;
    bit    in_idle_on   = 1'b1;
    bit    out_idle_on  = 1'b1;
    string keywords[5]  = '{"if", "else", "while", "for", "return"};

    c_subset_lexer_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // transfer monitor and quiet-cycle count for the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_byte(i_in_data);
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_token(o_out_data);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // receiver stalls in short random bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (out_idle_on && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog: too long without any transfer
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // one input transfer, optionally after a short idle burst
    task automatic send_byte(input logic [7:0] b, input logic eoi, input bit counted);
        t_in item;
        if (in_idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        item.in_byte      = b;
        item.end_of_input = eoi;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        if (counted) begin
            items_sent++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], 1'b0, 1'b1);
        end
    endtask

    // hold the sender until every expected token has come out
    task automatic drain_tokens();
        i_in_valid <= 1'b0;
        while (sb.expected_tokens.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
                                    : 8'($urandom_range("A", "Z"));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range("0", "9")) : rand_letter();
    endfunction

    // mostly short lexemes, now and then a long one that may run past the length cap
    function automatic int rand_lexeme_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 8);
    endfunction

    // one source fragment with random content, then maybe a separator
    task automatic send_fragment();
        int          n;
        logic [7:0]  sep;
        string       punct;
        punct = ";,(){}";
        case ($urandom_range(0, 12))
            0, 1: begin
                send_text(keywords[$urandom_range(0, 4)]);
                if ($urandom_range(0, 3) == 0) begin
                    send_byte(rand_alnum(), 1'b0, 1'b1);
                end
            end
            2, 3: begin
                n = rand_lexeme_len();
                send_byte(rand_letter(), 1'b0, 1'b1);
                for (int i = 1; i < n; i++) begin
                    send_byte(rand_alnum(), 1'b0, 1'b1);
                end
            end
            4: begin
                n = rand_lexeme_len();
                for (int i = 0; i < n; i++) begin
                    send_byte(8'($urandom_range("0", "9")), 1'b0, 1'b1);
                end
            end
            5, 6: send_byte(punct[$urandom_range(0, 5)], 1'b0, 1'b1);
            7: begin
                send_byte("+", 1'b0, 1'b1);
                case ($urandom_range(0, 2))
                    0: send_byte("+", 1'b0, 1'b1);
                    1: send_byte("=", 1'b0, 1'b1);
                    default: ;
                endcase
            end
            8: begin
                send_byte("=", 1'b0, 1'b1);
                if ($urandom_range(0, 1) == 0) begin
                    send_byte("=", 1'b0, 1'b1);
                end
            end
            9: begin
                send_byte("%", 1'b0, 1'b1);
                send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
            10: send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            11: send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            default: send_byte(8'($urandom_range(128, 255)), 1'b0, 1'b1);
        endcase
        // adjacent fragments half the time, to exercise the lookahead paths
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 2))
                0: sep = " ";
                1: sep = "\t";
                default: sep = "\n";
            endcase
            send_byte(sep, 1'b0, 1'b1);
        end
    endtask

    // stimulus and end of run
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every punctuation and operator kind, if and end, two-token bytes, percent, byte extremes
        send_text("(){},;++ +=+x==%");
        send_byte(8'hff, 1'b0, 1'b1);
        send_text("=;");
        send_byte(8'h00, 1'b0, 1'b1);
        send_text("if");
        send_byte(8'hff, 1'b1, 1'b1);
        drain_tokens();

        // random streams with idling on both sides
        while (items_sent < 800) send_fragment();
        drain_tokens();
        while (items_sent < 1600) send_fragment();

        // last part without idling
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        while (items_sent < 1950) send_fragment();
        send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        drain_tokens();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
